[hdl/hotp_pkg.sv]
// Shared types, constants and small tables for the HOTP truncation block.
package hotp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_HASH_KIND    = 2'd0;
  localparam logic [1:0] CFG_DIGIT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_APPEND_CHECK = 2'd2;
  localparam logic [1:0] CFG_FIXED_OFFSET = 2'd3;

  // Hash kinds
  localparam logic [1:0] HK_SHA1    = 2'd0;
  localparam logic [1:0] HK_SHA256  = 2'd1;
  localparam logic [1:0] HK_SHA512  = 2'd2;
  localparam logic [1:0] HK_INVALID = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HASH   = 2'd1;
  localparam logic [1:0] ST_BAD_DIGITS = 2'd2;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

  // Divider widths: 31-bit window, divisor up to 10^8
  localparam int DIV_W  = 31;
  localparam int DVS_W  = 27;
  localparam int CNT_W  = 7;
  localparam logic [CNT_W-1:0] CNT_SAT = 7'h7f;

  // Divide by ten for values below 2^27: q = (x * RECIP10) >> RECIP_SH
  localparam int               RECIP_SH = 30;
  localparam logic [DVS_W-1:0] RECIP10  = 27'd107374183;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [29:0] code_value;
    logic [3:0]  code_length;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic             push;
    logic             last;
    logic [7:0]       data;
  } buf_wr_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] digest_len(input logic [1:0] hk);
    logic [CNT_W-1:0] len;
    unique case (hk)
      HK_SHA1:   len = 7'd20;
      HK_SHA256: len = 7'd32;
      default:   len = 7'd64;
    endcase
    return len;
  endfunction

  function automatic logic [DVS_W-1:0] pow10(input logic [3:0] n);
    logic [DVS_W-1:0] p;
    case (n)
      4'd1:    p = 27'd10;
      4'd2:    p = 27'd100;
      4'd3:    p = 27'd1000;
      4'd4:    p = 27'd10000;
      4'd5:    p = 27'd100000;
      4'd6:    p = 27'd1000000;
      4'd7:    p = 27'd10000000;
      4'd8:    p = 27'd100000000;
      default: p = 27'd1;
    endcase
    return p;
  endfunction

  // Digit doubled, digits of the product summed
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/hotp_stream_if.sv]
// Valid/ready word channel with a typed payload.
interface hotp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/hotp_digest_buf.sv]
// Digest byte store and saturating byte counter.
module hotp_digest_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hotp_pkg::buf_wr_t          wr,
  input  logic [AW-1:0]              rd_addr,
  output logic [7:0]                 rd_data_r,
  output logic [hotp_pkg::CNT_W-1:0] cnt_inc
);
  import hotp_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // count including the word now arriving
  assign cnt_inc = (count_r == CNT_SAT) ? CNT_SAT : count_r + 7'd1;

  always_comb begin
    count_nxt = count_r;
    if (wr.push) begin
      count_nxt = wr.last ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // bytes past the store depth are counted only
  always_ff @(posedge clk) begin
    if (wr.push && (count_r < CNT_W'(DEPTH))) begin
      mem[count_r[AW-1:0]] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[hdl/hotp_div_unit.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module hotp_div_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  hotp_pkg::div_req_t  req,
  output hotp_pkg::div_rsp_t  rsp
);
  import hotp_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quot_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quot_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIV_W-2:0], fits};
      rem_r  <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

[hdl/hotp_truncate_to_digits.sv]
// Top level: HOTP dynamic truncation, decimal reduction and check digit.
//
// Digest bytes arrive on in_ch, most significant first, one word per cycle
// while the block is idle; a word without last_byte leaves it idle. The word
// marked last starts the truncation and the block stays busy (in_ch.ready
// low) until the result is in the output register, including any wait for
// the output register to free up. The bit-serial divider does the modulo by
// 10^digit_count. Each check-digit step then is a reciprocal multiply for
// the divide by ten (S_CK) and a shift-add remainder (S_CKW). The offset
// byte and the four window bytes take five reads of the single read port of
// the digest store. A word with an error status (bad hash kind first, then
// wrong digest length, then bad digit count) goes through S_DONE into the
// output register, with code and length zero, once that register is free.
// The output register holds one result on out_ch, so the next digest may
// stream in while that result waits. The user must write configuration
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
module hotp_truncate_to_digits #(
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  hotp_stream_if.sink   in_ch,
  hotp_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import hotp_pkg::*;

  localparam int AW = $clog2(MAX_DIGEST_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_OFS, S_OFSW, S_WIN, S_WCAP, S_MOD, S_MODW, S_CK, S_CKW, S_FIN, S_DONE
  } state_t;

  // configuration registers
  logic [1:0] hash_kind_r;
  logic [3:0] digit_count_r;
  logic       append_check_r;
  logic [6:0] fixed_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_kind_r    <= HK_SHA1;
      digit_count_r  <= 4'd6;
      append_check_r <= 1'b0;
      fixed_offset_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HASH_KIND:    hash_kind_r    <= cfg_data[1:0];
        CFG_DIGIT_COUNT:  digit_count_r  <= cfg_data[3:0];
        CFG_APPEND_CHECK: append_check_r <= cfg_data[0];
        CFG_FIXED_OFFSET: fixed_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t       state_r, state_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [1:0]   k_r, k_nxt;
  logic [DIV_W-1:0] win_r, win_nxt;
  logic [DVS_W-1:0] code_r, code_nxt;
  logic [DVS_W-1:0] work_r, work_nxt;
  logic [DVS_W-1:0] quo_r, quo_nxt;
  logic [3:0]   dig_r, dig_nxt;
  logic [3:0]   total_r, total_nxt;
  logic         dbl_r, dbl_nxt;
  logic [29:0]  res_code_r, res_code_nxt;
  logic [3:0]   res_len_r, res_len_nxt;
  logic [1:0]   res_status_r, res_status_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_word_t    out_word_r, out_word_nxt;

  buf_wr_t          buf_wr;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] cnt_inc;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [CNT_W-1:0]   len;
  logic               in_acc;
  logic [2*DVS_W-1:0] prod;
  logic [3:0]         dgt;
  logic [3:0]         add;
  logic [4:0]         sum;
  logic [3:0]         chk;

  assign len    = digest_len(hash_kind_r);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign buf_wr.push = in_acc;
  assign buf_wr.last = in_ch.data.last_byte;
  assign buf_wr.data = in_ch.data.digest_byte;

  // final digest byte first, then the four window bytes
  assign rd_addr = (state_r == S_OFS) ? AW'(len - 7'd1) : off_r + AW'(k_r);

  hotp_digest_buf #(
    .DEPTH (MAX_DIGEST_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (buf_wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .cnt_inc   (cnt_inc)
  );

  hotp_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // check digit: work / 10 by reciprocal multiply, digit = work - 10 * quotient;
  // the running total is kept modulo ten
  assign prod = {{DVS_W{1'b0}}, work_r} * {{DVS_W{1'b0}}, RECIP10};
  assign dgt  = 4'(work_r - ((quo_r << 3) + (quo_r << 1)));
  assign add  = dbl_r ? dbl_digit(dgt) : dgt;
  assign sum  = {1'b0, total_r} + {1'b0, add};
  assign chk  = (total_r == 4'd0) ? 4'd0 : 4'd10 - total_r;

  always_comb begin
    state_nxt      = state_r;
    off_nxt        = off_r;
    k_nxt          = k_r;
    win_nxt        = win_r;
    code_nxt       = code_r;
    work_nxt       = work_r;
    quo_nxt        = quo_r;
    dig_nxt        = dig_r;
    total_nxt      = total_r;
    dbl_nxt        = dbl_r;
    res_code_nxt   = res_code_r;
    res_len_nxt    = res_len_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    div_req.start    = 1'b0;
    div_req.dividend = win_r;
    div_req.divisor  = pow10(digit_count_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.data.last_byte) begin
          res_code_nxt   = '0;
          res_len_nxt    = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          if (hash_kind_r == HK_INVALID) begin
            res_status_nxt = ST_BAD_HASH;
          end else if (cnt_inc != len || len > CNT_W'(MAX_DIGEST_BYTES)) begin
            res_status_nxt = ST_BAD_LENGTH;
          end else if (digit_count_r < 4'd1 || digit_count_r > 4'd8) begin
            res_status_nxt = ST_BAD_DIGITS;
          end else begin
            state_nxt = S_OFS;
          end
        end
      end
      S_OFS: begin
        state_nxt = S_OFSW;
      end
      S_OFSW: begin
        off_nxt   = (fixed_offset_r < len - 7'd4) ? AW'(fixed_offset_r) : AW'(rd_data[3:0]);
        k_nxt     = '0;
        state_nxt = S_WIN;
      end
      S_WIN: begin
        state_nxt = S_WCAP;
      end
      S_WCAP: begin
        // top bit of the first byte falls off the 31-bit window
        win_nxt   = {win_r[DIV_W-9:0], rd_data};
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_MOD : S_WIN;
      end
      S_MOD: begin
        div_req.start = 1'b1;
        state_nxt     = S_MODW;
      end
      S_MODW: begin
        if (div_rsp.done) begin
          code_nxt = div_rsp.rem;
          work_nxt = div_rsp.rem;
          if (append_check_r) begin
            dig_nxt   = '0;
            total_nxt = '0;
            dbl_nxt   = 1'b1;
            state_nxt = S_CK;
          end else begin
            res_code_nxt = 30'(div_rsp.rem);
            res_len_nxt  = digit_count_r;
            state_nxt    = S_DONE;
          end
        end
      end
      S_CK: begin
        quo_nxt   = DVS_W'(prod[2*DVS_W-1:RECIP_SH]);
        state_nxt = S_CKW;
      end
      S_CKW: begin
        total_nxt = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
        work_nxt  = quo_r;
        dbl_nxt   = !dbl_r;
        dig_nxt   = dig_r + 4'd1;
        state_nxt = (dig_r + 4'd1 == digit_count_r) ? S_FIN : S_CK;
      end
      S_FIN: begin
        res_code_nxt = (30'(code_r) << 3) + (30'(code_r) << 1) + 30'(chk);
        res_len_nxt  = digit_count_r + 4'd1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_word_nxt.code_value  = res_code_r;
          out_word_nxt.code_length = res_len_r;
          out_word_nxt.status      = res_status_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r        <= off_nxt;
    k_r          <= k_nxt;
    win_r        <= win_nxt;
    code_r       <= code_nxt;
    work_r       <= work_nxt;
    quo_r        <= quo_nxt;
    dig_r        <= dig_nxt;
    total_r      <= total_nxt;
    dbl_r        <= dbl_nxt;
    res_code_r   <= res_code_nxt;
    res_len_r    <= res_len_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
  end

`ifndef SYNTH
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.data.last_byte |=> state_r != S_IDLE)
    else $error("last byte did not start truncation");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.status != ST_OK |->
      out_word_r.code_value == '0 && out_word_r.code_length == '0)
    else $error("error result carries a code");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.status == ST_OK |->
      out_word_r.code_length == digit_count_r + 4'(append_check_r))
    else $error("code length disagrees with configuration");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");
`endif

endmodule
